// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the clipper core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define MRC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked at every clock edge, reset included.
`define MRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/mrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mrc_pkg
// Types and constants shared by the range clipper core and its region table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mrc_pkg;

   localparam int MRC_MAX_REGIONS = 16;
   localparam int COUNT_W         = 5;
   localparam int INDEX_W         = 4;
   localparam int ADDR_W          = 64;

   // Request operation codes.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [INDEX_W-1:0] entry_index;
      logic [ADDR_W-1:0] range_start;
      logic [ADDR_W-1:0] range_end;
      logic              anonymous_flag;
      logic              writable_flag;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] segment_start;
      logic [ADDR_W-1:0] segment_end;
      logic              segment_valid;
      logic              last_result;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] region_start;
      logic [ADDR_W-1:0] region_end;
      logic              anonymous;
      logic              writable;
   } region_entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } mrc_state_type;

endpackage

// ===== rtl/core/mrc_region_mem.sv =====
// ----------------------------------------------------------------------------
// mrc_region_mem
// Region table: one write port, one read port with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrc_region_mem import mrc_pkg::*; #(
   parameter int DEPTH = MRC_MAX_REGIONS,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  region_entry_type wr_entry,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output region_entry_type rd_entry
);

   region_entry_type mem [DEPTH];
   region_entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   // The read data holds while no read is issued, so a stalled scan keeps it.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

// ===== rtl/core/migratable_range_clipper_core.sv =====
// ----------------------------------------------------------------------------
// migratable_range_clipper_core
// Clips a query address range against a table of anonymous, writable regions.
// ----------------------------------------------------------------------------
// Order: a write is acknowledged in the cycle after it is accepted; a query
//   scans min(region_count, MAX_REGIONS) table entries, then gives its final
//   response, reading one entry per cycle unless a hit stalls the scan.
// Throughput: one write per cycle while the response side takes each ack; a
//   new query is taken only in IDLE, once the last one's final response is registered.
// Reset: synchronous, clears the control state and region_count; the region
//   table is not cleared and holds whatever was last written.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module migratable_range_clipper_core import mrc_pkg::*; #(
   parameter int MAX_REGIONS = MRC_MAX_REGIONS
) (
   input  logic               clock,
   input  logic               reset,
   // Request channel.
   input  logic               req_valid,
   output logic               req_ready,
   input  req_type            req_payload,
   // Response channel.
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_type            rsp_payload,
   // Configuration: region_count.
   input  logic               csr_wr_en,
   input  logic [COUNT_W-1:0] csr_wr_data
);

   // Table address width and a scan pointer wide enough to hold the depth.
   localparam int AW    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CNT_W = $clog2(MAX_REGIONS + 1);

   // Control state.
   mrc_state_type      state_ff, state_in;
   logic [COUNT_W-1:0] count_ff;
   logic [CNT_W-1:0]   ptr_ff;
   logic [CNT_W-1:0]   limit;
   logic               eval_vld_ff, eval_vld_in;
   logic               pend_vld_ff;
   logic               rsp_valid_ff;

   // Payload state.
   logic [ADDR_W-1:0]  qs_ff, qe_ff;
   logic [ADDR_W-1:0]  pend_start_ff, pend_end_ff;
   rsp_type            rsp_ff;

   // Table ports.
   logic               mem_wr_en, mem_rd_en;
   logic [AW-1:0]      mem_wr_addr, mem_rd_addr;
   region_entry_type   wr_entry, rd_entry;

   // Scan datapath and handshake control.
   logic [ADDR_W-1:0]  clip_start, clip_end;
   logic               hit, stall, out_free, req_fire;
   logic               is_write, is_query, push_ack, push_seg, push_final;

   // -------------------------------------------------------------------------
   // Region table. Writes happen only in IDLE and reads only in SCAN, so the
   // state machine itself keeps a read and a write of one entry apart and no
   // forwarding path is needed.
   // -------------------------------------------------------------------------
   assign wr_entry.region_start = req_payload.range_start;
   assign wr_entry.region_end   = req_payload.range_end;
   assign wr_entry.anonymous    = req_payload.anonymous_flag;
   assign wr_entry.writable     = req_payload.writable_flag;
   assign mem_wr_addr           = AW'(req_payload.entry_index);
   assign mem_rd_addr           = ptr_ff[AW-1:0];

   mrc_region_mem #(
      .DEPTH (MAX_REGIONS),
      .AW    (AW)
   ) u_region_mem (
      .clock    (clock),
      .wr_en    (mem_wr_en),
      .wr_addr  (mem_wr_addr),
      .wr_entry (wr_entry),
      .rd_en    (mem_rd_en),
      .rd_addr  (mem_rd_addr),
      .rd_entry (rd_entry)
   );

   // -------------------------------------------------------------------------
   // Scan evaluation. The entry last read from the table is clipped against
   // the query; a qualifying non-empty clip is a hit.
   // -------------------------------------------------------------------------
   // A count above the table size scans the whole table.
   assign limit = (32'(count_ff) > MAX_REGIONS) ? CNT_W'(MAX_REGIONS)
                                                : CNT_W'(count_ff);

   assign clip_start = (rd_entry.region_start > qs_ff) ? rd_entry.region_start : qs_ff;
   assign clip_end   = (rd_entry.region_end   < qe_ff) ? rd_entry.region_end   : qe_ff;
   assign hit        = eval_vld_ff && rd_entry.anonymous && rd_entry.writable &&
                       (clip_end > clip_start);

   // The response register is free when empty or when it drains this cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_write = (req_payload.operation == OP_WRITE);
   assign is_query = (req_payload.operation == OP_QUERY);
   assign req_fire = req_valid && req_ready;

   // A write to a slot beyond the table stores nothing but is acknowledged.
   assign mem_wr_en = req_fire && is_write && (32'(req_payload.entry_index) < MAX_REGIONS);
   assign push_ack  = req_fire && is_write;

   // -------------------------------------------------------------------------
   // State machine outputs. The last hit of a query is only known once the
   // scan ends, so each hit is parked in a pending slot and sent when the next
   // hit arrives (not last) or in FLUSH (marked last). The scan stalls only
   // when a hit must push the pending segment into a full response register.
   // -------------------------------------------------------------------------
   always_comb begin
      req_ready  = 1'b0;
      stall      = 1'b0;
      mem_rd_en  = 1'b0;
      push_seg   = 1'b0;
      push_final = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = out_free;
         end
         ST_SCAN: begin
            stall = hit && pend_vld_ff && !out_free;
            if (!stall) begin
               mem_rd_en = (ptr_ff < limit);
               push_seg  = hit && pend_vld_ff;
            end
         end
         ST_FLUSH: begin
            push_final = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && is_query) begin
               // An empty query goes straight to the single no-segment response.
               state_in = (req_payload.range_start < req_payload.range_end) ? ST_SCAN
                                                                            : ST_FLUSH;
            end
         end
         ST_SCAN: begin
            // No further read and the last read entry is consumed this cycle.
            if (!stall && !mem_rd_en) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The read data stays valid across a stall; otherwise it follows the read.
   assign eval_vld_in = stall ? eval_vld_ff : mem_rd_en;

   // -------------------------------------------------------------------------
   // Control registers.
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ptr_ff       <= '0;
         eval_vld_ff  <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         eval_vld_ff <= eval_vld_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         if (req_fire) begin
            ptr_ff <= '0;
         end else if (mem_rd_en) begin
            ptr_ff <= ptr_ff + CNT_W'(1);
         end
         if (req_fire) begin
            pend_vld_ff <= 1'b0;
         end else if (push_final) begin
            pend_vld_ff <= 1'b0;
         end else if (hit && !stall) begin
            pend_vld_ff <= 1'b1;
         end
         if (push_ack || push_seg || push_final) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Payload registers.
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_fire && is_query) begin
         qs_ff <= req_payload.range_start;
         qe_ff <= req_payload.range_end;
      end
      if (hit && !stall) begin
         pend_start_ff <= clip_start;
         pend_end_ff   <= clip_end;
      end
      if (push_ack) begin
         rsp_ff <= '{segment_start: '0, segment_end: '0,
                     segment_valid: 1'b0, last_result: 1'b1};
      end else if (push_seg) begin
         rsp_ff <= '{segment_start: pend_start_ff, segment_end: pend_end_ff,
                     segment_valid: 1'b1, last_result: 1'b0};
      end else if (push_final) begin
         // A query with no hit gives one response that carries no segment.
         rsp_ff <= '{segment_start: pend_vld_ff ? pend_start_ff : '0,
                     segment_end:   pend_vld_ff ? pend_end_ff   : '0,
                     segment_valid: pend_vld_ff,
                     last_result:   1'b1};
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // -------------------------------------------------------------------------
   // Assertions.
   // -------------------------------------------------------------------------
   `MRC_ASSERT(a_ptr_in_range, clock, reset,
      (state_ff == ST_SCAN) |-> (ptr_ff <= limit),
      "scan pointer passed the region count")
   `MRC_ASSERT_ALWAYS(a_no_rd_wr_overlap, clock,
      !(mem_wr_en && mem_rd_en),
      "table read and write in the same cycle")
   `MRC_ASSERT(a_pend_nonempty, clock, reset,
      pend_vld_ff |-> (pend_end_ff > pend_start_ff),
      "pending segment is empty")
   `MRC_ASSERT(a_seg_nonempty, clock, reset,
      (rsp_valid_ff && rsp_ff.segment_valid) |-> (rsp_ff.segment_end > rsp_ff.segment_start),
      "response segment is empty")
   `MRC_ASSERT(a_flush_ends_last, clock, reset,
      push_final |=> (state_ff == ST_IDLE) && rsp_valid_ff && rsp_ff.last_result,
      "query did not end with a last response")

endmodule

// ===== dv/migratable_range_clipper_core_tb.sv =====
// ----------------------------------------------------------------------------
// migratable_range_clipper_core_tb
// Self-checking bench for the range clipper core. Region table writes and
// range queries go in on the request channel while the response side stalls
// at random. A scoreboard keeps its own copy of the region table and of
// region_count, works out the clipped segments for every accepted query and
// compares each response field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module migratable_range_clipper_core_tb;
   import mrc_pkg::*;

   // Longest run of cycles with no handshake on either channel, set well above
   // the slowest legal stretch of a query with a segment from every slot while
   // the response side stalls.
   localparam int STALL_LIMIT = 2000;
   // Cycles allowed after the last response for stray extra responses.
   localparam int TAIL_CYCLES = 24;
   localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

   // -------------------------------------------------------------------------
   // Scoreboard: a private copy of the region table and the count register,
   // and the queue of responses the block still owes.
   // -------------------------------------------------------------------------
   class clip_scoreboard;
      logic [ADDR_W-1:0]  region_lo   [MRC_MAX_REGIONS];
      logic [ADDR_W-1:0]  region_hi   [MRC_MAX_REGIONS];
      logic               region_anon [MRC_MAX_REGIONS];
      logic               region_wr   [MRC_MAX_REGIONS];
      logic [COUNT_W-1:0] count_reg;
      rsp_type            pending_responses[$];
      int                 writes_seen;
      int                 queries_seen;
      int                 segments_checked;
      int                 mismatches;

      function new();
         count_reg        = '0;
         writes_seen      = 0;
         queries_seen     = 0;
         segments_checked = 0;
         mismatches       = 0;
      endfunction

      // Append one owed response at the tail of the queue.
      function void owe_response(rsp_type res);
         pending_responses = {pending_responses, res};
      endfunction

      // Work out what an accepted request must produce and queue it.
      function void note_request(req_type r);
         rsp_type           res;
         int                scan;
         int                hits;
         logic [ADDR_W-1:0] lo;
         logic [ADDR_W-1:0] hi;
         hits = 0;
         res  = '0;
         if (r.operation == OP_WRITE) begin
            writes_seen++;
            if (r.entry_index < MRC_MAX_REGIONS) begin
               region_lo[r.entry_index]   = r.range_start;
               region_hi[r.entry_index]   = r.range_end;
               region_anon[r.entry_index] = r.anonymous_flag;
               region_wr[r.entry_index]   = r.writable_flag;
            end
            res.last_result = 1'b1;
            owe_response(res);
            return;
         end
         queries_seen++;
         if (r.range_start < r.range_end) begin
            scan = (count_reg > MRC_MAX_REGIONS) ? MRC_MAX_REGIONS : int'(count_reg);
            for (int i = 0; i < scan; i++) begin
               if (region_anon[i] && region_wr[i]) begin
                  lo = (region_lo[i] > r.range_start) ? region_lo[i] : r.range_start;
                  hi = (region_hi[i] < r.range_end) ? region_hi[i] : r.range_end;
                  if (hi > lo) begin
                     res.segment_start = lo;
                     res.segment_end   = hi;
                     res.segment_valid = 1'b1;
                     res.last_result   = 1'b0;
                     owe_response(res);
                     hits++;
                  end
               end
            end
         end
         if (hits == 0) begin
            res = '0;
            res.last_result = 1'b1;
            owe_response(res);
         end else begin
            pending_responses[pending_responses.size() - 1].last_result = 1'b1;
         end
      endfunction

      task report_mismatch(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
         $display("ERROR at %0t ns: %s got %h expected %h", $time, what, got, want);
         mismatches++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (pending_responses.size() == 0) begin
            report_mismatch("response with nothing outstanding, segment_start",
                            got.segment_start, '0);
            return;
         end
         want = pending_responses.pop_front();
         if (want.segment_valid)
            segments_checked++;
         if (got.segment_start !== want.segment_start)
            report_mismatch("segment_start", got.segment_start, want.segment_start);
         if (got.segment_end !== want.segment_end)
            report_mismatch("segment_end", got.segment_end, want.segment_end);
         if (got.segment_valid !== want.segment_valid)
            report_mismatch("segment_valid", ADDR_W'(got.segment_valid),
                            ADDR_W'(want.segment_valid));
         if (got.last_result !== want.last_result)
            report_mismatch("last_result", ADDR_W'(got.last_result),
                            ADDR_W'(want.last_result));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the signals that drive the block. Every input starts
   // at a known value so that nothing is X while reset is high.
   // -------------------------------------------------------------------------
   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_ready;
   req_type            req_payload = '0;
   logic               rsp_valid;
   logic               rsp_ready   = 1'b0;
   rsp_type            rsp_payload;
   logic               csr_wr_en   = 1'b0;
   logic [COUNT_W-1:0] csr_wr_data = '0;

   clip_scoreboard     sb;
   bit                 no_idle       = 1'b0;
   int                 idle_cycles   = 0;
   int                 config_writes = 0;
   // Where the current table lives, so that most queries land on it.
   logic [ADDR_W-1:0]  window_base   = '0;
   logic [ADDR_W-1:0]  window_span   = '0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   migratable_range_clipper_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // -------------------------------------------------------------------------
   // Random helpers.
   // -------------------------------------------------------------------------
   function automatic logic [ADDR_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Uniform-ish value in 0 .. n; n never reaches the all-ones address here.
   function automatic logic [ADDR_W-1:0] rand_upto(logic [ADDR_W-1:0] n);
      return rand64() % (n + 64'd1);
   endfunction

   // Each side draws a random idle gap before every request or response, except
   // in the stretches where no_idle forces back-to-back traffic.
   function automatic int draw_gap();
      return no_idle ? 0 : int'($urandom_range(0, 6));
   endfunction

   // -------------------------------------------------------------------------
   // Request side. Valid rises after the drawn gap and then holds, with the
   // payload steady, until the block takes the request. Handshakes are read
   // in the active region right after the edge, so they see the values that
   // the block sampled at that edge.
   // -------------------------------------------------------------------------
   task automatic send_request(req_type item);
      int gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
   endtask

   task automatic send_write(logic [INDEX_W-1:0] idx, logic [ADDR_W-1:0] lo,
                             logic [ADDR_W-1:0] hi, bit anon, bit wr);
      req_type r;
      r                = '0;
      r.operation      = OP_WRITE;
      r.entry_index    = idx;
      r.range_start    = lo;
      r.range_end      = hi;
      r.anonymous_flag = anon;
      r.writable_flag  = wr;
      send_request(r);
   endtask

   task automatic send_query(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
      req_type r;
      r                = '0;
      r.operation      = OP_QUERY;
      r.entry_index    = INDEX_W'($urandom);
      r.range_start    = lo;
      r.range_end      = hi;
      r.anonymous_flag = 1'($urandom);
      r.writable_flag  = 1'($urandom);
      send_request(r);
   endtask

   // Hold off new requests until every owed response has come back and the
   // block shows it is ready again. This is also the sender's long pause.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_responses.size() != 0 || !req_ready);
   endtask

   // region_count only changes while the block is idle.
   task automatic set_region_count(logic [COUNT_W-1:0] value);
      wait_until_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      sb.count_reg = value;
      config_writes++;
   endtask

   // -------------------------------------------------------------------------
   // Stimulus.
   // -------------------------------------------------------------------------

   // Fill all sixteen slots with ascending, non-overlapping regions of random
   // size. The step size is drawn per table so that both tiny and very wide
   // regions show up, and the base is random so high address bits toggle.
   task automatic rebuild_table(bit all_flags);
      logic [ADDR_W-1:0] step_mask;
      logic [ADDR_W-1:0] room;
      logic [ADDR_W-1:0] cursor;
      logic [ADDR_W-1:0] lo;
      logic [ADDR_W-1:0] hi;
      int                sel;
      sel = int'($urandom_range(0, 3));
      case (sel)
         0: step_mask = 64'hF;
         1: step_mask = 64'hFFF;
         2: step_mask = 64'hF_FFFF;
         default: step_mask = 64'hFFFF_FFFF;
      endcase
      room   = (step_mask + 64'd1) * 64;
      cursor = rand64();
      if (cursor > ~room)
         cursor = cursor - room;
      window_base = cursor;
      for (int i = 0; i < MRC_MAX_REGIONS; i++) begin
         lo     = cursor + (rand64() & step_mask);
         hi     = lo + (rand64() & step_mask);
         cursor = hi;
         send_write(INDEX_W'(i), lo, hi,
                    all_flags || ($urandom_range(0, 3) != 0),
                    all_flags || ($urandom_range(0, 3) != 0));
      end
      window_span = cursor - window_base;
   endtask

   // Mostly queries that land on the current table; the rest are whole-space
   // queries, empty or reversed ranges, wild addresses and stray writes that
   // leave the table overlapping or out of order.
   task automatic send_random_request();
      logic [ADDR_W-1:0] a;
      logic [ADDR_W-1:0] b;
      int                pick;
      pick = int'($urandom_range(0, 9));
      case (pick)
         0, 1, 2, 3, 4, 5: begin
            a = window_base + rand_upto(window_span + 64'd64);
            b = a + rand_upto(window_span / 2 + 64'd16);
            send_query(a, b);
         end
         6: begin
            if ($urandom_range(0, 1))
               send_query(window_base, window_base + window_span);
            else
               send_query('0, ADDR_MAX);
         end
         7: begin
            a = rand64();
            b = $urandom_range(0, 1) ? a : (a & rand64());
            send_query(a, b);
         end
         8: send_query(rand64(), rand64());
         default: begin
            a = window_base + rand_upto(window_span);
            b = a + rand_upto(window_span / 4);
            send_write(INDEX_W'($urandom), a, b, 1'($urandom), 1'($urandom));
         end
      endcase
   endtask

   // Directed opening: count zero from reset, a hand-made table with every
   // flag combination, an empty region, an overlapping region and one that
   // reaches the top of the address space, then the extremes of region_count.
   task automatic run_directed();
      logic [ADDR_W-1:0] lo;
      logic [ADDR_W-1:0] hi;
      // Nothing is scanned while region_count is still zero.
      send_query(64'h0, 64'h100);
      for (int i = 0; i < 14; i++) begin
         lo = 64'h1000 * (i + 1);
         hi = (i == 4) ? lo : lo + 64'h800;
         send_write(INDEX_W'(i), lo, hi, (i % 4) < 2, (i % 4) == 0 || (i % 4) == 2);
      end
      // Slot 14 overlaps several earlier regions; slot 15 ends at the top.
      send_write(INDEX_W'(14), 64'h1800, 64'h9800, 1'b1, 1'b1);
      send_write(INDEX_W'(15), 64'hF000_0000_0000_0000, ADDR_MAX, 1'b1, 1'b1);

      set_region_count(COUNT_W'(MRC_MAX_REGIONS));
      send_query('0, ADDR_MAX);
      send_query(ADDR_MAX, ADDR_MAX);
      send_query(64'h5000, 64'h10);
      send_query(64'h1400, 64'h5400);
      send_query(64'hA000_0000, 64'hB000_0000);

      // Counts above the table size must scan just the sixteen slots.
      set_region_count('1);
      send_query(64'h8000_0000_0000_0000, ADDR_MAX);

      set_region_count(COUNT_W'(1));
      send_query('0, ADDR_MAX);
   endtask

   // One random phase: a new count, a fresh table, then mixed traffic.
   task automatic run_phase(logic [COUNT_W-1:0] count, bit all_flags, bit burst);
      set_region_count(count);
      no_idle = burst;
      rebuild_table(all_flags);
      repeat (14) send_random_request();
      no_idle = 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Response side: draws a stall before each response, then holds ready
   // until a response is taken and checks it against the oldest expectation.
   // -------------------------------------------------------------------------
   initial begin : response_sink
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_response(rsp_payload);
      end
   end

   // Watchdog: any cycle with a handshake on either channel counts as
   // progress. A block that hangs ends the run here.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
         $display("migratable_range_clipper_core regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin : main_sequence
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // Full tables and saturated counts come first so that the longest
      // queries, with a segment from every slot, are exercised early.
      run_phase(COUNT_W'(MRC_MAX_REGIONS), 1'b1, 1'b0);
      run_phase('1, 1'b0, 1'b1);
      run_phase(COUNT_W'($urandom_range(0, 31)), 1'b0, 1'b0);
      run_phase(COUNT_W'(MRC_MAX_REGIONS + 1), 1'b1, 1'b0);
      run_phase(COUNT_W'(8), 1'b0, 1'b1);
      run_phase(COUNT_W'($urandom_range(2, 15)), 1'b0, 1'b0);

      // Let everything owed arrive, then give stray responses time to show.
      wait_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d table writes and %0d queries over %0d region_count settings.",
               sb.writes_seen, sb.queries_seen, config_writes);
      $display("Checked %0d clipped segments; %0d mismatches.",
               sb.segments_checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_responses.size() == 0) begin
         $display("migratable_range_clipper_core regression: pass");
      end else begin
         $display("migratable_range_clipper_core regression: fail");
      end
      $finish;
   end

endmodule

// ===== migratable_range_clipper_core.f =====
+incdir+rtl/core
rtl/core/mrc_pkg.sv
rtl/core/mrc_region_mem.sv
rtl/core/migratable_range_clipper_core.sv
dv/migratable_range_clipper_core_tb.sv
